### src/scfp_pkg.sv
// Shared definitions for the sum-checked frame parser.
// Holds field widths, frame marker bytes, event codes and register map.
// No dependencies.
`default_nettype none

package scfp_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    // Frame marker bytes
    localparam logic [BYTE_W-1:0] HDR1_BYTE = 8'h53;
    localparam logic [BYTE_W-1:0] HDR2_BYTE = 8'h59;
    localparam logic [BYTE_W-1:0] TAIL1_BYTE = 8'h54;
    localparam logic [BYTE_W-1:0] TAIL2_BYTE = 8'h43;
    localparam logic [BYTE_W-1:0] LENH_BYTE = 8'h00;

    // Register reset values
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'hff;

    // Register map (byte addresses)
    localparam logic [APB_AW-1:0] ADDR_MAX_LEN = 3'd0;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_PAYLOAD   = 3'd1,
        EV_FRAME     = 3'd2,
        EV_SUM_ERR   = 3'd3,
        EV_LEN_ERR   = 3'd4,
        EV_FRAME_ERR = 3'd5
    } t_event;

endpackage

`default_nettype wire

### src/sum_checked_frame_parser.sv
// Byte-serial frame parser with 8-bit sum check; one result word per byte.
// Depends on scfp_pkg for widths, marker bytes, event codes and register map.
//
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) takes one received
//   byte per word. Output channel (o_res_valid / i_res_stall / result fields)
//   returns one word per byte: an event code, the current frame's control,
//   command and length, and the payload byte with its position.
//   A byte accepted at an edge shows its result at the outputs right after
//   that edge. Throughput is one byte per cycle unless the receiver stalls;
//   the frame state and the result register update together at the accept edge.
//   The result register forms the output stage: while it holds a word the
//   receiver stalls, o_rx_stall is raised so no new byte enters; once the
//   word is taken a new byte is accepted in the same cycle.
//   The APB port holds max_len at address 0 (reset 255); write it only while
//   the parser is idle.
//   Reset (i_rst_n low, synchronous) empties the output stage, sets the
//   parser to wait for the first header byte and clears the frame fields.
`default_nettype none

module sum_checked_frame_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // APB configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [scfp_pkg::APB_AW-1:0]     paddr,
    input  wire logic [scfp_pkg::APB_DW-1:0]     pwdata,
    output logic      [scfp_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready,
    // Input byte channel
    input  wire logic                            i_rx_valid,
    output logic                                 o_rx_stall,
    input  wire logic [scfp_pkg::BYTE_W-1:0]     i_rx_byte,
    // Result channel
    output logic                                 o_res_valid,
    input  wire logic                            i_res_stall,
    output logic      [scfp_pkg::EVENT_W-1:0]    o_event_res,
    output logic      [scfp_pkg::BYTE_W-1:0]     o_control_code,
    output logic      [scfp_pkg::BYTE_W-1:0]     o_command_code,
    output logic      [scfp_pkg::BYTE_W-1:0]     o_payload_len,
    output logic      [scfp_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic      [scfp_pkg::BYTE_W-1:0]     o_payload_pos
);

    typedef enum logic [3:0] {
        PH_H1   = 4'd0,
        PH_H2   = 4'd1,
        PH_CON  = 4'd2,
        PH_CMD  = 4'd3,
        PH_LENH = 4'd4,
        PH_LENL = 4'd5,
        PH_DATA = 4'd6,
        PH_SUM  = 4'd7,
        PH_T1   = 4'd8,
        PH_T2   = 4'd9
    } t_phase;

    localparam int unsigned BW = scfp_pkg::BYTE_W;

    t_phase                      r_phase, n_phase;
    logic [BW-1:0]               r_sum, n_sum;
    logic [BW-1:0]               r_ctrl, n_ctrl;
    logic [BW-1:0]               r_cmd, n_cmd;
    logic [BW-1:0]               r_len, n_len;
    logic [BW-1:0]               r_pos, n_pos;
    logic [BW-1:0]               r_max_len;
    scfp_pkg::t_event            n_event;
    logic [BW-1:0]               n_pbyte, n_ppos;
    logic [BW-1:0]               pos_inc;

    logic                        r_res_valid;
    scfp_pkg::t_event            r_event;
    logic [BW-1:0]               r_pbyte, r_ppos;

    logic                        rx_accept;
    logic                        cfg_write;
    logic                        is_hdr1;
    t_phase                      resync_phase;
    logic [BW-1:0]               resync_sum;

    // Configuration register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == scfp_pkg::ADDR_MAX_LEN);

    always_comb begin
        prdata = '0;
        if (paddr == scfp_pkg::ADDR_MAX_LEN) begin
            prdata = {{(scfp_pkg::APB_DW-BW){1'b0}}, r_max_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= scfp_pkg::MAX_LEN_RESET;
        end else if (cfg_write) begin
            r_max_len <= pwdata[BW-1:0];
        end
    end

    // Take a byte whenever the output stage is empty or being drained
    assign o_rx_stall = r_res_valid && i_res_stall;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    // Resync target: an offending first-header byte opens a new frame
    assign is_hdr1      = (i_rx_byte == scfp_pkg::HDR1_BYTE);
    assign resync_phase = is_hdr1 ? PH_H2 : PH_H1;
    assign resync_sum   = is_hdr1 ? i_rx_byte : r_sum;
    assign pos_inc      = r_pos + 8'd1;

    // Decode one byte against the frame layout
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_ctrl  = r_ctrl;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_pos   = r_pos;
        n_event = scfp_pkg::EV_NONE;
        n_pbyte = '0;
        n_ppos  = '0;
        case (r_phase)
            PH_H2: begin
                if (i_rx_byte == scfp_pkg::HDR2_BYTE) begin
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_CON;
                end else begin
                    n_event = scfp_pkg::EV_FRAME_ERR;
                    n_phase = resync_phase;
                    n_sum   = resync_sum;
                end
            end
            PH_CON: begin
                n_ctrl  = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_LENH;
            end
            PH_LENH: begin
                if (i_rx_byte != scfp_pkg::LENH_BYTE) begin
                    n_event = scfp_pkg::EV_LEN_ERR;
                    n_phase = resync_phase;
                    n_sum   = resync_sum;
                end else begin
                    n_len   = '0;
                    n_phase = PH_LENL;
                end
            end
            PH_LENL: begin
                if (i_rx_byte > r_max_len) begin
                    n_event = scfp_pkg::EV_LEN_ERR;
                    n_phase = resync_phase;
                    n_sum   = resync_sum;
                end else begin
                    n_len   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_pos   = '0;
                    n_phase = (i_rx_byte != '0) ? PH_DATA : PH_SUM;
                end
            end
            PH_DATA: begin
                n_event = scfp_pkg::EV_PAYLOAD;
                n_pbyte = i_rx_byte;
                n_ppos  = r_pos;
                n_sum   = r_sum + i_rx_byte;
                n_pos   = pos_inc;
                if (pos_inc >= r_len) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (i_rx_byte == r_sum) begin
                    n_phase = PH_T1;
                end else begin
                    n_event = scfp_pkg::EV_SUM_ERR;
                    n_phase = resync_phase;
                    n_sum   = resync_sum;
                end
            end
            PH_T1: begin
                if (i_rx_byte == scfp_pkg::TAIL1_BYTE) begin
                    n_phase = PH_T2;
                end else begin
                    n_event = scfp_pkg::EV_FRAME_ERR;
                    n_phase = resync_phase;
                    n_sum   = resync_sum;
                end
            end
            PH_T2: begin
                if (i_rx_byte == scfp_pkg::TAIL2_BYTE) begin
                    n_event = scfp_pkg::EV_FRAME;
                    n_phase = PH_H1;
                end else begin
                    n_event = scfp_pkg::EV_FRAME_ERR;
                    n_phase = resync_phase;
                    n_sum   = resync_sum;
                end
            end
            default: begin
                // Wait for the first header byte
                n_phase = resync_phase;
                n_sum   = resync_sum;
            end
        endcase
    end

    // Hold frame state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_H1;
            r_sum       <= '0;
            r_ctrl      <= '0;
            r_cmd       <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (rx_accept) begin
                r_phase     <= n_phase;
                r_sum       <= n_sum;
                r_ctrl      <= n_ctrl;
                r_cmd       <= n_cmd;
                r_len       <= n_len;
                r_pos       <= n_pos;
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Load the per-byte result payload
    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_event <= n_event;
            r_pbyte <= n_pbyte;
            r_ppos  <= n_ppos;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_event_res    = r_event;
    assign o_control_code = r_ctrl;
    assign o_command_code = r_cmd;
    assign o_payload_len  = r_len;
    assign o_payload_byte = r_pbyte;
    assign o_payload_pos  = r_ppos;

endmodule

`default_nettype wire

### src/scfp_checker.sv
// Port-level checker for the sum-checked frame parser, bound to the top level.
// Depends on scfp_pkg for widths and event codes.
`default_nettype none

module scfp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_rx_valid,
    input wire logic                         o_rx_stall,
    input wire logic                         o_res_valid,
    input wire logic                         i_res_stall,
    input wire logic [scfp_pkg::EVENT_W-1:0] o_event_res,
    input wire logic [scfp_pkg::BYTE_W-1:0]  o_payload_len,
    input wire logic [scfp_pkg::BYTE_W-1:0]  o_payload_byte,
    input wire logic [scfp_pkg::BYTE_W-1:0]  o_payload_pos
);

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_event_res)
            && $stable(o_payload_byte) && $stable(o_payload_pos))
        else $error("stalled result word changed");

    // Every accepted byte yields a result word next cycle
    a_byte_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_valid && !o_rx_stall |=> o_res_valid)
        else $error("accepted byte produced no result");

    // Payload fields are zero outside payload events
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_event_res != scfp_pkg::EV_PAYLOAD)
            |-> (o_payload_byte == '0) && (o_payload_pos == '0))
        else $error("payload fields set outside a payload event");

    // Payload position stays inside the declared length
    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_event_res == scfp_pkg::EV_PAYLOAD)
            |-> o_payload_pos < o_payload_len)
        else $error("payload position beyond declared length");

endmodule

bind sum_checked_frame_parser scfp_checker u_scfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_valid     (i_rx_valid),
    .o_rx_stall     (o_rx_stall),
    .o_res_valid    (o_res_valid),
    .i_res_stall    (i_res_stall),
    .o_event_res    (o_event_res),
    .o_payload_len  (o_payload_len),
    .o_payload_byte (o_payload_byte),
    .o_payload_pos  (o_payload_pos)
);

`default_nettype wire
